/* design/mtah_pkg.sv */
// shared types, constants and codes of the temperature alarm monitor
`default_nettype none

package mtah_pkg;

    // number of monitored devices
    localparam int NUM_DEVICES = 16;

    // field widths
    localparam int DEV_W   = 4;
    localparam int TEMP_W  = 16;
    localparam int LVL_W   = 2;
    localparam int EV_W    = 3;
    localparam int NUM_W   = 32;
    localparam int CLR_W   = 5;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // devices reachable through the index field, and the table index width
    localparam int ENTRIES = (NUM_DEVICES < (1 << DEV_W)) ? NUM_DEVICES : (1 << DEV_W);
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // request codes
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_ACK    = 1'b1;

    // alarm levels
    localparam logic [LVL_W-1:0] LVL_NONE = 2'd0;
    localparam logic [LVL_W-1:0] LVL_WARN = 2'd1;
    localparam logic [LVL_W-1:0] LVL_CRIT = 2'd2;

    // event codes
    localparam logic [EV_W-1:0] EV_NONE      = 3'd0;
    localparam logic [EV_W-1:0] EV_RAISED    = 3'd1;
    localparam logic [EV_W-1:0] EV_ESCALATED = 3'd2;
    localparam logic [EV_W-1:0] EV_RESTORED  = 3'd3;
    localparam logic [EV_W-1:0] EV_IGNORED   = 3'd4;
    localparam logic [EV_W-1:0] EV_ACK       = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WARN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESTORE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd3;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] WARN_RST    = 16'd960;
    localparam logic [CFG_W-1:0] CRIT_RST    = 16'd1200;
    localparam logic [CFG_W-1:0] RESTORE_RST = 16'd928;
    localparam logic [CFG_W-1:0] ENABLE_RST  = 16'd0;

    // configuration as seen by the datapath
    typedef struct packed {
        logic signed [TEMP_W-1:0] warn;
        logic signed [TEMP_W-1:0] crit;
        logic signed [TEMP_W-1:0] restore;
        logic [CFG_W-1:0]         dev_enable;
    } t_cfg;

    // one entry of the per-device alarm table
    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [NUM_W-1:0] tag;
    } t_entry;

endpackage

`default_nettype wire

/* design/multichannel_temp_alarm_hysteresis_top.sv */
// top level of the multichannel temperature alarm monitor with hysteresis
//
// usage
//   input channel: i_in_valid / o_in_stall carry one item (a device sample or
//   an acknowledge) per handshake; output channel: o_out_valid / i_out_stall
//   carry exactly one result item per input item, in order
//   each item is handled in turn: the accept cycle reads the per-device table
//   (level and alarm number) from a synchronous memory into a register; the
//   commit step then evaluates the thresholds, writes the table back and
//   loads the output register; a new item is taken only after that commit,
//   so only one item is in flight at a time
//   the output register decouples the sides: an item is still taken while a
//   finished result waits; while the receiver stalls with a result pending,
//   the next item's commit holds until the output register frees up
//   alarm-active flags live in flip-flops so acknowledge clears all at once
//   reset (synchronous, active low) clears the active flags, sets the alarm
//   counter to one and loads the default thresholds; the table needs no clear
//   configuration is written through i_cfg_we / i_cfg_index / i_cfg_data
`default_nettype none

module multichannel_temp_alarm_hysteresis_top (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration
    input  wire logic                                  i_cfg_we,
    input  wire logic [mtah_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [mtah_pkg::CFG_W-1:0]            i_cfg_data,
    // input channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic                                  i_req_type,
    input  wire logic [mtah_pkg::DEV_W-1:0]            i_device_index,
    input  wire logic                                  i_online,
    input  wire logic signed [mtah_pkg::TEMP_W-1:0]    i_temperature,
    // output channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic [mtah_pkg::DEV_W-1:0]                 o_out_device,
    output logic [mtah_pkg::LVL_W-1:0]                 o_alarm_level,
    output logic [mtah_pkg::EV_W-1:0]                  o_event_res,
    output logic [mtah_pkg::NUM_W-1:0]                 o_alarm_number,
    output logic [mtah_pkg::CLR_W-1:0]                 o_cleared_count
);

    mtah_pkg::t_cfg w_cfg;

    mtah_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // control state
    logic                                r_busy;
    logic [mtah_pkg::ENTRIES-1:0]        r_active;
    logic [mtah_pkg::ENTRIES-1:0]        n_active;
    logic [mtah_pkg::NUM_W-1:0]          r_next_number;
    logic [mtah_pkg::NUM_W-1:0]          n_next_number;
    logic                                r_out_valid;

    // item held during evaluation
    logic                                r_req;
    logic [mtah_pkg::DEV_W-1:0]          r_dev;
    logic                                r_online;
    logic signed [mtah_pkg::TEMP_W-1:0]  r_temp;

    // per-device table, one read and at most one write-back per item
    mtah_pkg::t_entry                    r_mem [mtah_pkg::ENTRIES];
    mtah_pkg::t_entry                    r_rd_data;
    mtah_pkg::t_entry                    w_wr_data;
    logic                                w_mem_we;

    // result registers
    logic [mtah_pkg::DEV_W-1:0]          r_o_dev;
    logic [mtah_pkg::LVL_W-1:0]          r_o_lvl;
    logic [mtah_pkg::EV_W-1:0]           r_o_ev;
    logic [mtah_pkg::NUM_W-1:0]          r_o_num;
    logic [mtah_pkg::CLR_W-1:0]          r_o_clr;
    logic [mtah_pkg::DEV_W-1:0]          n_o_dev;
    logic [mtah_pkg::LVL_W-1:0]          n_o_lvl;
    logic [mtah_pkg::EV_W-1:0]           n_o_ev;
    logic [mtah_pkg::NUM_W-1:0]          n_o_num;
    logic [mtah_pkg::CLR_W-1:0]          n_o_clr;

    logic                                w_in_accept;
    logic                                w_commit;
    logic [mtah_pkg::IDX_W-1:0]          w_rd_idx;
    logic [mtah_pkg::IDX_W-1:0]          w_idx;
    logic                                w_valid_dev;
    logic                                w_cur_active;
    logic [mtah_pkg::LVL_W-1:0]          w_lvl;

    // one item in flight at a time
    assign o_in_stall  = r_busy;
    assign w_in_accept = i_in_valid && !r_busy;
    // evaluation finishes when the output register is free or being drained
    assign w_commit    = r_busy && (!r_out_valid || !i_out_stall);

    assign w_rd_idx = i_device_index[mtah_pkg::IDX_W-1:0];
    assign w_idx    = r_dev[mtah_pkg::IDX_W-1:0];

    // table memory: read on accept, written back on commit
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_idx] <= w_wr_data;
        end
        if (w_in_accept) begin
            r_rd_data <= r_mem[w_rd_idx];
        end
    end

    // capture the item
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_req    <= i_req_type;
            r_dev    <= i_device_index;
            r_online <= i_online;
            r_temp   <= i_temperature;
        end
    end

    // evaluation of the held item
    always_comb begin
        w_valid_dev   = (32'(r_dev) < 32'(mtah_pkg::NUM_DEVICES))
                        && w_cfg.dev_enable[r_dev];
        w_cur_active  = r_active[w_idx];
        n_active      = r_active;
        n_next_number = r_next_number;
        w_mem_we      = 1'b0;
        w_wr_data     = r_rd_data;
        n_o_dev       = r_dev;
        n_o_lvl       = mtah_pkg::LVL_NONE;
        n_o_ev        = mtah_pkg::EV_NONE;
        n_o_num       = '0;
        n_o_clr       = '0;

        // critical test first, then warning
        if (r_online && (r_temp >= w_cfg.crit)) begin
            w_lvl = mtah_pkg::LVL_CRIT;
        end else if (r_online && (r_temp >= w_cfg.warn)) begin
            w_lvl = mtah_pkg::LVL_WARN;
        end else begin
            w_lvl = mtah_pkg::LVL_NONE;
        end

        if (r_req == mtah_pkg::REQ_ACK) begin
            n_o_clr  = mtah_pkg::CLR_W'($countones(r_active));
            n_active = '0;
            n_o_dev  = '0;
            n_o_ev   = mtah_pkg::EV_ACK;
        end else if (!w_valid_dev) begin
            n_o_ev = mtah_pkg::EV_IGNORED;
        end else if (w_lvl != mtah_pkg::LVL_NONE) begin
            if (!w_cur_active) begin
                // new alarm with a fresh number
                w_mem_we         = 1'b1;
                w_wr_data.level  = w_lvl;
                w_wr_data.tag    = r_next_number;
                n_next_number    = r_next_number + 1'b1;
                n_active[w_idx]  = 1'b1;
                n_o_ev           = mtah_pkg::EV_RAISED;
                n_o_num          = r_next_number;
                n_o_lvl          = w_lvl;
            end else if (w_lvl > r_rd_data.level) begin
                w_mem_we        = 1'b1;
                w_wr_data.level = w_lvl;
                n_o_ev          = mtah_pkg::EV_ESCALATED;
                n_o_num         = r_rd_data.tag;
                n_o_lvl         = w_lvl;
            end else begin
                // levels never drop
                n_o_lvl = r_rd_data.level;
            end
        end else if (w_cur_active && (!r_online || (r_temp <= w_cfg.restore))) begin
            n_active[w_idx] = 1'b0;
            n_o_ev          = mtah_pkg::EV_RESTORED;
            n_o_num         = r_rd_data.tag;
        end

        // nothing changes until the result can be stored
        if (!w_commit) begin
            w_mem_we      = 1'b0;
            n_active      = r_active;
            n_next_number = r_next_number;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_active      <= '0;
            r_next_number <= mtah_pkg::NUM_W'(1);
            r_out_valid   <= 1'b0;
        end else begin
            r_active      <= n_active;
            r_next_number <= n_next_number;
            if (w_in_accept) begin
                r_busy <= 1'b1;
            end else if (w_commit) begin
                r_busy <= 1'b0;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_o_dev <= n_o_dev;
            r_o_lvl <= n_o_lvl;
            r_o_ev  <= n_o_ev;
            r_o_num <= n_o_num;
            r_o_clr <= n_o_clr;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_device    = r_o_dev;
    assign o_alarm_level   = r_o_lvl;
    assign o_event_res     = r_o_ev;
    assign o_alarm_number  = r_o_num;
    assign o_cleared_count = r_o_clr;

    // acknowledge leaves no alarm active
    a_ack_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && (r_req == mtah_pkg::REQ_ACK)) |=> (r_active == '0))
        else $error("active alarms remain after acknowledge");

    // a raised alarm carries the counter value and advances it by one
    a_raise_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && (n_o_ev == mtah_pkg::EV_RAISED))
        |=> ((o_alarm_number == $past(r_next_number))
             && (r_next_number == $past(r_next_number) + 1'b1)))
        else $error("raised alarm number mismatch");

    // the counter only moves when an alarm is raised
    a_counter_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_commit && (n_o_ev == mtah_pkg::EV_RAISED)) |=> $stable(r_next_number))
        else $error("alarm counter moved without a raise");

    // every accepted item is finished before the next one is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_busy && o_in_stall))
        else $error("item accepted while another is in flight");

    // a commit always presents a result
    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (o_out_valid && !r_busy))
        else $error("commit without result");

endmodule

`default_nettype wire

/* design/mtah_cfg.sv */
// configuration registers of the temperature alarm monitor
`default_nettype none

module mtah_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mtah_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mtah_pkg::CFG_W-1:0]      i_cfg_data,
    output mtah_pkg::t_cfg                       o_cfg
);

    logic [mtah_pkg::CFG_W-1:0] r_warn;
    logic [mtah_pkg::CFG_W-1:0] r_crit;
    logic [mtah_pkg::CFG_W-1:0] r_restore;
    logic [mtah_pkg::CFG_W-1:0] r_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn    <= mtah_pkg::WARN_RST;
            r_crit    <= mtah_pkg::CRIT_RST;
            r_restore <= mtah_pkg::RESTORE_RST;
            r_enable  <= mtah_pkg::ENABLE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mtah_pkg::REG_WARN:    r_warn    <= i_cfg_data;
                mtah_pkg::REG_CRIT:    r_crit    <= i_cfg_data;
                mtah_pkg::REG_RESTORE: r_restore <= i_cfg_data;
                mtah_pkg::REG_ENABLE:  r_enable  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.warn       = $signed(r_warn);
    assign o_cfg.crit       = $signed(r_crit);
    assign o_cfg.restore    = $signed(r_restore);
    assign o_cfg.dev_enable = r_enable;

endmodule

`default_nettype wire
